@@ sv/upc_pkg.sv @@
// Package: shared constants, types and character-class helpers for the percent codec.
`default_nettype none
package upc_pkg;

	localparam int unsigned BYTE_W  = 8;
	localparam int unsigned NIB_W   = 4;
	localparam int unsigned CFG_IDX_W = 1;
	localparam int unsigned CFG_DAT_W = 1;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_DECODE_MODE = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_KEEP_SLASH  = 1'b1;

	localparam logic [BYTE_W-1:0] CH_PERCENT = 8'h25;
	localparam logic [BYTE_W-1:0] CH_SLASH   = 8'h2F;
	localparam logic [BYTE_W-1:0] CH_TILDE   = 8'h7E;
	localparam logic [BYTE_W-1:0] CH_UNDER   = 8'h5F;
	localparam logic [BYTE_W-1:0] CH_DASH    = 8'h2D;
	localparam logic [BYTE_W-1:0] CH_DOT     = 8'h2E;

	typedef enum logic [1:0] {
		PH_IDLE   = 2'd0,
		PH_FIRST  = 2'd1,
		PH_SECOND = 2'd2
	} phase_t;

	typedef struct packed {
		logic [BYTE_W-1:0] out_byte;
		logic              run_last;
		logic              out_end;
		logic              error;
	} result_t;

	typedef struct packed {
		logic             ok;
		logic [NIB_W-1:0] value;
	} hex_t;

	function automatic hex_t hex_value(input logic [BYTE_W-1:0] c);
		hex_t r;
		r.ok    = 1'b1;
		r.value = c[NIB_W-1:0];
		if (c >= 8'h30 && c <= 8'h39) begin
			r.value = c[NIB_W-1:0];
		end else if ((c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66)) begin
			r.value = c[NIB_W-1:0] + 4'd9;
		end else begin
			r.ok    = 1'b0;
			r.value = '0;
		end
		return r;
	endfunction

	function automatic logic is_unreserved(input logic [BYTE_W-1:0] c, input logic slash_ok);
		return (c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A) ||
		       (c >= 8'h30 && c <= 8'h39) || c == CH_UNDER || c == CH_DASH ||
		       c == CH_TILDE || c == CH_DOT || (slash_ok && c == CH_SLASH);
	endfunction

	// Upper-case hex digit for one nibble
	function automatic logic [BYTE_W-1:0] hex_digit(input logic [NIB_W-1:0] n);
		if (n < 4'd10) begin
			return 8'h30 + {4'd0, n};
		end else begin
			return 8'h37 + {4'd0, n};
		end
	endfunction

endpackage
`default_nettype wire

@@ sv/upc_channels.sv @@
// Interfaces: input byte, result and configuration write channels of the percent codec.
`default_nettype none
interface upc_in_if;
	logic                       valid;
	logic                       ready;
	logic [upc_pkg::BYTE_W-1:0] data_byte;
	logic                       string_end;

	modport source (output valid, output data_byte, output string_end, input ready);
	modport sink   (input valid, input data_byte, input string_end, output ready);
endinterface

interface upc_out_if;
	logic                       valid;
	logic                       ready;
	logic [upc_pkg::BYTE_W-1:0] out_byte;
	logic                       run_last;
	logic                       out_end;
	logic                       error;

	modport source (output valid, output out_byte, output run_last, output out_end,
		output error, input ready);
	modport sink   (input valid, input out_byte, input run_last, input out_end,
		input error, output ready);
endinterface

interface upc_cfg_if;
	logic                          valid;
	logic                          ready;
	logic [upc_pkg::CFG_IDX_W-1:0] index;
	logic [upc_pkg::CFG_DAT_W-1:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink   (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

@@ sv/uri_percent_codec.sv @@
// Top level: streaming percent-encoding / decoding codec, one byte per input beat.
//
//  channel  | dir | payload                              | accepted when
//  ---------+-----+--------------------------------------+---------------------
//  in_ch    | in  | data_byte[7:0], string_end           | valid & ready
//  out_ch   | out | out_byte[7:0], run_last, out_end, error | valid & ready
//  cfg_ch   | in  | index (0 decode_mode, 1 keep_slash), data | valid & ready (ready tied high)
//
// An accepted beat sits in the s1 register; short logic there forms its results and
// loads them one per cycle, while out_ch does not stall, into the output register. A byte
// with one result retires as it is loaded, one with none at once; such bytes stream back
// to back. An escaped byte in encode mode holds s1 for its three output beats. A stall on
// out_ch holds the output register and, through it, in_ch.ready and any s1 byte with results.
// Reset clears the mode registers, the escape state and all valid flags; no clearing pass.
`default_nettype none
module uri_percent_codec (
	input  wire logic clk,
	input  wire logic arst_n,
	upc_in_if.sink    in_ch,
	upc_out_if.source out_ch,
	upc_cfg_if.sink   cfg_ch
);
	import upc_pkg::*;

	// Configuration registers
	logic decode_mode_q;
	logic keep_slash_q;

	// Input stage
	logic              valid_s1;
	logic [BYTE_W-1:0] byte_s1;
	logic              end_s1;
	logic [1:0]        beat_idx_q;

	// Escape state
	phase_t           phase_q;
	logic [NIB_W-1:0] nibble_q;
	logic             discard_q;

	// Output register
	logic    out_valid_q;
	result_t out_q;

	// Combinational view of the s1 item
	hex_t             hx;
	logic             plain;
	logic [1:0]       n_results;
	result_t          res;
	phase_t           phase_d;
	logic [NIB_W-1:0] nibble_d;
	logic             discard_d;
	logic             dec_emit;
	result_t          dec_res;
	logic             out_load_ok;
	logic             emit;
	logic             retire;

	assign cfg_ch.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			decode_mode_q <= 1'b0;
			keep_slash_q  <= 1'b0;
		end else if (cfg_ch.valid) begin
			unique case (cfg_ch.index)
				CFG_DECODE_MODE: decode_mode_q <= cfg_ch.data[0];
				CFG_KEEP_SLASH:  keep_slash_q  <= cfg_ch.data[0];
				default: ;
			endcase
		end
	end

	// Decode: work out the single result (if any) and the next escape state
	always_comb begin
		hx        = hex_value(byte_s1);
		dec_emit  = 1'b0;
		dec_res   = '{out_byte: '0, run_last: 1'b1, out_end: end_s1, error: 1'b0};
		phase_d   = phase_q;
		nibble_d  = nibble_q;
		discard_d = discard_q;
		if (discard_q) begin
			// Drop bytes; only the end of the string reports
			dec_emit        = end_s1;
			dec_res.error   = 1'b1;
			dec_res.out_end = 1'b1;
		end else if (phase_q == PH_FIRST || phase_q == PH_SECOND) begin
			if (!hx.ok) begin
				dec_emit      = 1'b1;
				dec_res.error = 1'b1;
				phase_d       = PH_IDLE;
				nibble_d      = '0;
				discard_d     = 1'b1;
			end else if (phase_q == PH_FIRST) begin
				if (end_s1) begin
					// Truncated escape
					dec_emit        = 1'b1;
					dec_res.error   = 1'b1;
					dec_res.out_end = 1'b1;
				end else begin
					nibble_d = hx.value;
					phase_d  = PH_SECOND;
				end
			end else begin
				dec_emit         = 1'b1;
				dec_res.out_byte = {nibble_q, hx.value};
				phase_d          = PH_IDLE;
				nibble_d         = '0;
			end
		end else begin
			if (byte_s1 == CH_PERCENT) begin
				if (end_s1) begin
					dec_emit        = 1'b1;
					dec_res.error   = 1'b1;
					dec_res.out_end = 1'b1;
				end else begin
					phase_d = PH_FIRST;
				end
			end else begin
				dec_emit         = 1'b1;
				dec_res.out_byte = byte_s1;
			end
		end
	end

	// Pick the result for the current output beat
	always_comb begin
		plain = is_unreserved(byte_s1, keep_slash_q);
		res   = dec_res;
		if (decode_mode_q) begin
			n_results = dec_emit ? 2'd1 : 2'd0;
		end else if (plain) begin
			n_results = 2'd1;
			res       = '{out_byte: byte_s1, run_last: 1'b1, out_end: end_s1, error: 1'b0};
		end else begin
			n_results = 2'd3;
			unique case (beat_idx_q)
				2'd0: res = '{out_byte: CH_PERCENT, run_last: 1'b0, out_end: 1'b0,
					error: 1'b0};
				2'd1: res = '{out_byte: hex_digit(byte_s1[BYTE_W-1:NIB_W]), run_last: 1'b0,
					out_end: 1'b0, error: 1'b0};
				default: res = '{out_byte: hex_digit(byte_s1[NIB_W-1:0]), run_last: 1'b1,
					out_end: end_s1, error: 1'b0};
			endcase
		end
	end

	assign out_load_ok = !out_valid_q || out_ch.ready;
	assign emit        = valid_s1 && n_results != 2'd0 && out_load_ok;
	// Retire s1 once its last beat is loaded, or at once when it yields nothing
	assign retire      = valid_s1 &&
		(n_results == 2'd0 || (out_load_ok && beat_idx_q == n_results - 2'd1));
	assign in_ch.ready = !valid_s1 || retire;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1   <= 1'b0;
			beat_idx_q <= '0;
			phase_q    <= PH_IDLE;
			nibble_q   <= '0;
			discard_q  <= 1'b0;
		end else begin
			if (retire) begin
				beat_idx_q <= '0;
				if (end_s1) begin
					phase_q   <= PH_IDLE;
					nibble_q  <= '0;
					discard_q <= 1'b0;
				end else if (decode_mode_q) begin
					phase_q   <= phase_d;
					nibble_q  <= nibble_d;
					discard_q <= discard_d;
				end
			end else if (emit) begin
				beat_idx_q <= beat_idx_q + 2'd1;
			end
			if (in_ch.valid && in_ch.ready) begin
				valid_s1 <= 1'b1;
			end else if (retire) begin
				valid_s1 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_ch.valid && in_ch.ready) begin
			byte_s1 <= in_ch.data_byte;
			end_s1  <= in_ch.string_end;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load_ok) begin
			out_valid_q <= emit;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			out_q <= res;
		end
	end

	assign out_ch.valid    = out_valid_q;
	assign out_ch.out_byte = out_q.out_byte;
	assign out_ch.run_last = out_q.run_last;
	assign out_ch.out_end  = out_q.out_end;
	assign out_ch.error    = out_q.error;

	// Beat counter never reaches past the third encode beat
	a_beat_range: assert property (@(posedge clk) disable iff (!arst_n)
		beat_idx_q != 2'd3)
		else $error("beat index out of range");

	// While dropping input no escape is open
	a_discard_idle: assert property (@(posedge clk) disable iff (!arst_n)
		discard_q |-> phase_q == PH_IDLE)
		else $error("discard with open escape");

	// An error beat carries a zero byte
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_q.error |-> out_q.out_byte == '0)
		else $error("error beat with nonzero byte");

	// End of string returns the escape state to idle
	a_end_clear: assert property (@(posedge clk) disable iff (!arst_n)
		retire && end_s1 |=> phase_q == PH_IDLE && !discard_q && nibble_q == '0)
		else $error("state not cleared at end of string");

endmodule
`default_nettype wire
